FILE: design/tmmp_pkg.sv
// ----------------------------------------------------------------------------
// tmmp_pkg
// Shared widths, register indexes and the command/status bundles passed
// between the trimmed-mean moisture controller and its datapath.
// ----------------------------------------------------------------------------
package tmmp_pkg;

    // ADC sample and result widths
    localparam int ADC_W = 12;
    localparam int PCT_W = 14;

    // full scale in hundredths of a percent
    localparam logic [PCT_W-1:0] SCALE_HUNDREDTHS = 14'd10000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL = 1'b1;

    // register reset values
    localparam logic [ADC_W-1:0] DRY_RESET = 12'hFFF;
    localparam logic [ADC_W-1:0] WET_RESET = 12'h000;

    // controller -> datapath commands
    typedef struct packed {
        logic acc;    // accept one sample into the window
        logic trim;   // form trimmed sum, clear window
        logic diff;   // clamp and subtract from the dry bound
        logic mult;   // scale difference to hundredths
        logic dinit;  // load divider
        logic div;    // one restoring division step
        logic oload;  // load the result register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic last;      // current sample closes the window
        logic out_free;  // result register can take a new item
    } t_status;

endpackage

FILE: design/tmmp_ctrl.sv
// ----------------------------------------------------------------------------
// tmmp_ctrl
// Sequencer for the trimmed-mean block: accepts samples while idle and,
// after the last sample of a window, steps the datapath through trimming,
// scaling and the serial division.
// ----------------------------------------------------------------------------
module tmmp_ctrl
    import tmmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int STEP_W = $clog2(PCT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PCT_W - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TRIM  = 7'b0000010,
        S_DIFF  = 7'b0000100,
        S_MULT  = 7'b0001000,
        S_DINIT = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.acc = w_accept;
                if (w_accept && i_status.last) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_step      = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_step    = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (i_status.out_free) begin
                    o_cmd.oload = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

FILE: design/tmmp_datapath.sv
// ----------------------------------------------------------------------------
// tmmp_datapath
// Window accumulators, calibration registers, clamp and scale stages, a
// restoring divider producing one quotient bit per cycle, and the result
// register.
// ----------------------------------------------------------------------------
module tmmp_datapath
    import tmmp_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [ADC_W-1:0]     i_sample,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADC_W-1:0]     i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [PCT_W-1:0]     o_pct,
    output logic                 o_calib_error
);

    localparam int ADC_MAX = (1 << ADC_W) - 1;
    localparam int TRIM_N  = WINDOW_SIZE - 2;
    localparam int SUM_W   = $clog2(WINDOW_SIZE * ADC_MAX + 1);
    localparam int CNT_W   = $clog2(WINDOW_SIZE);
    localparam int TW      = $clog2(TRIM_N + 1);
    localparam int NUM_W   = SUM_W + PCT_W;
    localparam logic [TW-1:0]    TRIM_C   = TW'(TRIM_N);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SIZE - 1);

    logic [ADC_W-1:0] r_dry, r_wet;
    logic [SUM_W-1:0] r_sum;
    logic [ADC_W-1:0] r_min, r_max;
    logic [CNT_W-1:0] r_count;

    logic [SUM_W-1:0] r_trim, r_hi, r_lo, r_span, r_diff, r_rem;
    logic [NUM_W-1:0] r_num;
    logic [PCT_W-1:0] r_quo;
    logic             r_cerr;

    logic             r_ovalid;
    logic [PCT_W-1:0] r_pct;
    logic             r_oerr;

    logic [SUM_W-1:0] w_clamp;
    logic [SUM_W:0]   w_trial;
    logic             w_ge;

    assign o_status.last     = (r_count == CNT_LAST);
    assign o_status.out_free = !r_ovalid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry <= DRY_RESET;
            r_wet <= WET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DRY_LEVEL: r_dry <= i_cfg_data;
                CFG_WET_LEVEL: r_wet <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window accumulation; trim clears the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_min   <= ADC_W'(ADC_MAX);
            r_max   <= '0;
            r_count <= '0;
        end else if (i_cmd.trim) begin
            r_sum <= '0;
            r_min <= ADC_W'(ADC_MAX);
            r_max <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SUM_W'(i_sample);
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            r_count <= o_status.last ? '0 : r_count + 1'b1;
        end
    end

    // clamp the trimmed sum into wet*T .. dry*T
    always_comb begin
        if (r_trim > r_hi) begin
            w_clamp = r_hi;
        end else if (r_trim < r_lo) begin
            w_clamp = r_lo;
        end else begin
            w_clamp = r_trim;
        end
    end

    // one restoring division step
    assign w_trial = {r_rem, r_quo[PCT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_span});

    // trim, scale and divide
    always_ff @(posedge i_clk) begin
        // capture calibration as it stands when the last sample is taken
        if (i_cmd.acc && o_status.last) begin
            r_hi   <= SUM_W'(r_dry) * SUM_W'(TRIM_C);
            r_lo   <= SUM_W'(r_wet) * SUM_W'(TRIM_C);
            r_span <= SUM_W'(r_dry - r_wet) * SUM_W'(TRIM_C);
            r_cerr <= (r_wet >= r_dry);
        end
        if (i_cmd.trim) begin
            r_trim <= r_sum - SUM_W'(r_min) - SUM_W'(r_max);
        end
        if (i_cmd.diff) begin
            r_diff <= r_hi - w_clamp;
        end
        if (i_cmd.mult) begin
            r_num <= NUM_W'(r_diff) * NUM_W'(SCALE_HUNDREDTHS);
        end
        if (i_cmd.dinit) begin
            r_rem <= r_num[NUM_W-1:PCT_W];
            r_quo <= r_num[PCT_W-1:0];
        end else if (i_cmd.div) begin
            r_rem <= w_ge ? SUM_W'(w_trial - {1'b0, r_span}) : w_trial[SUM_W-1:0];
            r_quo <= {r_quo[PCT_W-2:0], w_ge};
        end
    end

    // result register; force zero on bad calibration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.oload) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.oload) begin
            r_pct  <= r_cerr ? '0 : r_quo;
            r_oerr <= r_cerr;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_pct         = r_pct;
    assign o_calib_error = r_oerr;

endmodule

FILE: design/trimmed_mean_moisture_percent_core.sv
// ----------------------------------------------------------------------------
// trimmed_mean_moisture_percent_core
// Trimmed-mean oversampling of ADC samples with linear moisture calibration.
// ----------------------------------------------------------------------------
// Samples are accepted one per cycle while the block is idle. Every
// WINDOW_SIZE samples the smallest and largest are dropped, the mean of the
// rest is clamped to wet..dry and one result in hundredths of a percent is
// produced (dry 0, wet 10000, truncated); if wet is not below dry the result
// is 0 with the error flag set. The last sample of a window holds the input
// off through four set-up steps (trim, clamp, scale, divider load), the
// one-bit-per-cycle restoring divider and the load of the output register,
// which waits while the previous result is still held on the output.
// Calibration registers are written through the config channel, which is
// always ready.
module trimmed_mean_moisture_percent_core
    import tmmp_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input samples
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [11:0] sample, [15:12] zero
    // results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [13:0] percent_hundredths, [15:14] zero
    output logic                 m_axis_tuser,   // [0] calib_error
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADC_W-1:0]     i_cfg_data
);

    t_cmd             w_cmd;
    t_status          w_status;
    logic [PCT_W-1:0] w_pct;

    assign o_cfg_ready = 1'b1;

    tmmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tmmp_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sample      (s_axis_tdata[ADC_W-1:0]),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pct         (w_pct),
        .o_calib_error (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, w_pct};

endmodule

FILE: test/trimmed_mean_moisture_percent_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_mean_moisture_percent_core_tb
// Self-checking bench for the trimmed-mean moisture core. A queue of ADC
// samples feeds a clocked stream driver; a clocked monitor compares every
// result against a local window/calibration predictor. Calibration is
// changed between phases, including mid-window, and across its extremes.
// ----------------------------------------------------------------------------
module trimmed_mean_moisture_percent_core_tb;
    import tmmp_pkg::*;

    localparam int WIN        = 16;
    localparam int TRIM_COUNT = WIN - 2;
    localparam int IDLE_PCT   = 25;
    localparam int SETTLE_CYC = 30;
    localparam int RAND_ITEMS = 450;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic             calib_err;
    } moisture_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;   // [11:0] sample, [15:12] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // [13:0] percent_hundredths, [15:14] zero
    logic                 m_axis_tuser;        // [0] calib_error
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_DRY_LEVEL;
    logic [ADC_W-1:0]     i_cfg_data = '0;

    // samples waiting for the driver, results waiting for the monitor
    logic [ADC_W-1:0] sample_q[$];
    moisture_t        moisture_q[$];

    // predictor state
    logic [ADC_W-1:0] cal_dry = DRY_RESET;
    logic [ADC_W-1:0] cal_wet = WET_RESET;
    logic [16:0]      win_sum = '0;
    logic [ADC_W-1:0] win_min = '1;
    logic [ADC_W-1:0] win_max = '0;
    logic [5:0]       win_count = '0;

    logic steady = 1'b0;
    int   samples_taken = 0;
    int   samples_queued = 0;
    int   windows_seen = 0;
    int   bad_cal_seen = 0;
    int   mismatch_count = 0;

    trimmed_mean_moisture_percent_core #(
        .WINDOW_SIZE(WIN)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Accumulate one sample; on the window's last sample queue the moisture
    // value of the trimmed mean and clear the window.
    task automatic accumulate_sample(input logic [ADC_W-1:0] x);
        longint unsigned hi, lo, span, s;
        moisture_t       m;
        win_sum = win_sum + x;
        if (x < win_min) win_min = x;
        if (x > win_max) win_max = x;
        win_count = win_count + 1'b1;
        if (win_count < WIN) return;
        s = longint'(win_sum) - longint'(win_min) - longint'(win_max);
        if (cal_wet >= cal_dry) begin
            m.pct = '0;
            m.calib_err = 1'b1;
        end else begin
            hi = longint'(cal_dry) * TRIM_COUNT;
            lo = longint'(cal_wet) * TRIM_COUNT;
            span = TRIM_COUNT * longint'(cal_dry - cal_wet);
            if (s > hi) s = hi;
            if (s < lo) s = lo;
            m.pct = PCT_W'(((hi - s) * 10000) / span);
            m.calib_err = 1'b0;
        end
        moisture_q.push_back(m);
        win_sum = '0;
        win_min = '1;
        win_max = '0;
        win_count = '0;
    endtask

    // Pick a sample: mostly inside the calibration span, some anywhere,
    // some at the rails to exercise min/max trimming.
    function automatic logic [ADC_W-1:0] pick_sample();
        int lo, hi, r;
        lo = (cal_wet < cal_dry) ? cal_wet : cal_dry;
        hi = (cal_wet < cal_dry) ? cal_dry : cal_wet;
        r = $urandom_range(99);
        if (r < 55) return ADC_W'($urandom_range(hi, lo));
        if (r < 85) return ADC_W'($urandom_range(4095));
        return $urandom_range(1) ? 12'hFFF : 12'h000;
    endfunction

    // Stream driver: hold an item until taken, idle at random otherwise.
    always @(posedge i_clk) begin : drive_samples
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accumulate_sample(s_axis_tdata[ADC_W-1:0]);
                samples_taken++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (sample_q.size() > 0 &&
                         (steady || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0000, sample_q.pop_front()};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input moisture_t want,
                                   input moisture_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch (%s): expected pct=%0d err=%0b, got pct=%0d err=%0b",
                     $realtime, what, want.pct, want.calib_err, got.pct, got.calib_err);
    endtask

    // Result monitor: compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        moisture_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pct = m_axis_tdata[PCT_W-1:0];
                got.calib_err = m_axis_tuser;
                windows_seen++;
                if (got.calib_err) bad_cal_seen++;
                if (moisture_q.size() == 0) begin
                    report_mismatch("no result pending", '0, got);
                end else begin
                    want = moisture_q.pop_front();
                    if (got.pct !== want.pct || got.calib_err !== want.calib_err)
                        report_mismatch("field", want, got);
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [ADC_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DRY_LEVEL) cal_dry = val;
        else cal_wet = val;
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every sample is taken and every result checked, then let
    // the core settle before touching calibration again.
    task automatic drain();
        do @(posedge i_clk);
        while (sample_q.size() > 0 || s_axis_tvalid || moisture_q.size() > 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [ADC_W-1:0] dry, input logic [ADC_W-1:0] wet,
                             input int count);
        write_cal(CFG_DRY_LEVEL, dry);
        write_cal(CFG_WET_LEVEL, wet);
        @(posedge i_clk);
        for (int k = 0; k < count; k++) sample_q.push_back(pick_sample());
        samples_queued += count;
        drain();
    endtask

    initial begin : sequence_phases
        int phase;
        logic [ADC_W-1:0] d, w, tmp;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one window at reset calibration with both rails as the outliers
        sample_q.push_back(12'h000);
        sample_q.push_back(12'hFFF);
        for (int k = 0; k < WIN - 2; k++) sample_q.push_back(k[0] ? 12'hAAA : 12'h555);
        drain();

        // random phases; uneven lengths put calibration changes mid-window
        phase = 0;
        while (samples_queued < RAND_ITEMS) begin
            steady <= (phase == 4 || phase == 5);
            case (phase)
                0: begin d = 12'hFFF; w = 12'h000; end
                1: begin d = 12'h001; w = 12'h000; end
                2: begin d = 12'h800; w = 12'h800; end
                3: begin d = 12'h000; w = 12'hFFF; end
                4: begin d = 12'd3000; w = 12'd1200; end
                5: begin d = 12'hFFF; w = 12'hFFE; end
                6: begin d = 12'h000; w = 12'h000; end
                default: begin
                    d = ADC_W'($urandom_range(4095));
                    w = ADC_W'($urandom_range(4095));
                    if (w >= d && $urandom_range(4) != 0) begin
                        tmp = d;
                        d = w;
                        w = tmp;
                    end
                end
            endcase
            run_phase(d, w, $urandom_range(70, 20));
            phase++;
        end

        $display("Covered %0d samples in %0d windows over %0d calibration phases,",
                 samples_taken, windows_seen, phase + 1);
        $display("%0d windows with bad calibration, %0d mismatches.",
                 bad_cal_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** trimmed_mean_moisture_percent_core: PASSED **");
        end else begin
            $display("** trimmed_mean_moisture_percent_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d results still pending.", moisture_q.size());
        $display("** trimmed_mean_moisture_percent_core: FAILED **");
        $finish;
    end

endmodule
